### rtl/session_channel_table_unit_macros.svh
// Assertion macros shared by the session channel table checker.
`ifndef SESSION_CHANNEL_TABLE_UNIT_MACROS_SVH
`define SESSION_CHANNEL_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define SCT_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sct_pkg.sv
// Shared types, constants and helpers of the session channel table.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

	localparam int SESSION_SLOTS = 16;
	localparam int QUEUE_DEPTH   = 16;

	localparam int SLOT_AW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
	localparam int USE_W   = $clog2(SESSION_SLOTS + 1);
	localparam int POS_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int OB_W    = (LEN_W > 5) ? LEN_W : 5;
	localparam int WADDR_W = 1 + SLOT_AW + POS_W;

	typedef enum logic [2:0] {
		REQ_RESET_ALL = 3'd0,
		REQ_CREATE    = 3'd1,
		REQ_DROP      = 3'd2,
		REQ_SEND      = 3'd3,
		REQ_RECV      = 3'd4,
		REQ_QUERY     = 3'd5
	} req_kind_t;

	typedef enum logic [3:0] {
		STS_OK            = 4'd0,
		STS_INVALID_ARG   = 4'd1,
		STS_EXHAUSTED     = 4'd2,
		STS_NOT_FOUND     = 4'd3,
		STS_STALE         = 4'd4,
		STS_INVALID_STATE = 4'd5,
		STS_DISCONNECTED  = 4'd6,
		STS_FULL          = 4'd7,
		STS_WOULD_BLOCK   = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		SS_CLOSED = 2'd0,
		SS_OPEN   = 2'd1,
		SS_HALF   = 2'd2
	} sess_state_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_META,
		FSM_SWEEP,
		FSM_FIN
	} fsm_t;

	typedef struct packed {
		logic [15:0]      gen;
		sess_state_t      state;
		logic             ini_live;
		logic             rsp_live;
		logic [OB_W-1:0]  oblig;
		logic [LEN_W-1:0] cap;
		logic [POS_W-1:0] fwd_head;
		logic [LEN_W-1:0] fwd_len;
		logic [POS_W-1:0] bwd_head;
		logic [LEN_W-1:0] bwd_len;
	} slot_entry_t;

	typedef struct packed {
		logic               rd_en;
		logic [SLOT_AW-1:0] rd_addr;
		logic               wr_en;
		logic [SLOT_AW-1:0] wr_addr;
		slot_entry_t        wr_data;
	} meta_req_t;

	typedef struct packed {
		logic               rd_en;
		logic [WADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [WADDR_W-1:0] wr_addr;
		logic [63:0]        wr_data;
	} word_req_t;

	// Next generation tag; zero is never handed out.
	function automatic logic [15:0] gen_advance(input logic [15:0] g);
		return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
	endfunction

endpackage

`default_nettype wire

### rtl/sct_meta_store.sv
// Slot metadata memory: one entry per slot, registered read.
`timescale 1ns / 1ps
`default_nettype none

module sct_meta_store import sct_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire meta_req_t req,
	output slot_entry_t    rd_data
);

	slot_entry_t                mem [SESSION_SLOTS];
	slot_entry_t                mem_rd_q;
	logic [SESSION_SLOTS-1:0]   valid_q;
	logic                       valid_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q <= mem[req.rd_addr];
		end
	end

	// Entries never written read as the cleared slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_rd_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = valid_rd_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

### rtl/sct_word_store.sv
// Queue word memory for both directions of every slot, registered read.
`timescale 1ns / 1ps
`default_nettype none

module sct_word_store import sct_pkg::*; (
	input  wire logic      clk,
	input  wire word_req_t req,
	output logic [63:0]    rd_data
);

	logic [63:0] mem [2**WADDR_W];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/session_channel_table_unit.sv
// Top level of the session channel table: control sequencer and slot datapath.
//
// Request channel: req_valid / req_stall with req_type, slot, generation,
// from_initiator, value and capacity. An item is taken at an edge with
// req_valid high and req_stall low. Response channel: rsp_valid / rsp_stall
// carrying status, recv_word, out_slot, out_generation, session_state,
// obligations and partner_live; exactly one response per request, in order.
// Create, drop, send, receive and query read the slot entry as the item is
// taken, then modify it, write it back and stage the response (META), then
// load the response register (FIN). Reset all sweeps the slot memory one
// entry a cycle (SWEEP), then loads the response register (FIN).
// Only one item is in flight; its write-back lands before the next item's
// read, so no forwarding is needed.
// The response register parts the channels: the next item is taken while a
// response still waits. A stalled response holds and blocks only the
// completion of the following item.
// After arst_n every slot reads as closed with generation zero and no
// slot in use; queue word contents are undefined until sent.
`timescale 1ns / 1ps
`default_nettype none

module session_channel_table_unit import sct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [3:0]  slot,
	input  wire logic [15:0] generation,
	input  wire logic        from_initiator,
	input  wire logic [63:0] value,
	input  wire logic [7:0]  capacity,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [3:0]       status,
	output logic [63:0]      recv_word,
	output logic [3:0]       out_slot,
	output logic [15:0]      out_generation,
	output logic [1:0]       session_state,
	output logic [4:0]       obligations,
	output logic             partner_live
);

	localparam logic [SLOT_AW-1:0] SWEEP_LAST = SLOT_AW'(SESSION_SLOTS - 1);

	// Sequencer and bookkeeping
	fsm_t                     state_q, state_d;
	logic [USE_W-1:0]         in_use_q, in_use_d;
	logic [SESSION_SLOTS-1:0] closed_q, closed_d;
	logic [SLOT_AW-1:0]       sweep_q, sweep_d;

	// Held request
	logic [2:0]               kind_q;
	logic [3:0]               slot_q;
	logic [15:0]              gen_q;
	logic                     ini_q;
	logic [63:0]              value_q;
	logic [7:0]               cap_q;
	logic [SLOT_AW-1:0]       cr_idx_q;
	logic                     cr_append_q;
	status_t                  cr_status_q;

	// Staged response
	status_t                  res_status_q, res_status_d;
	logic                     res_recv_q, res_recv_d;
	logic [3:0]               res_slot_q, res_slot_d;
	logic [15:0]              res_gen_q, res_gen_d;
	sess_state_t              res_state_q, res_state_d;
	logic [4:0]               res_ob_q, res_ob_d;
	logic                     res_pa_q, res_pa_d;

	// Memory ports
	meta_req_t                meta_req;
	slot_entry_t              meta_rd;
	word_req_t                word_req;
	logic [63:0]              word_rd;

	// Handshake
	logic                     out_free;
	logic                     accept;
	logic                     is_rst_req;

	// Create slot choice, made as the item is taken
	logic                     pick_found;
	logic [SLOT_AW-1:0]       pick_idx;
	logic                     cap_ok;
	logic                     table_full;
	logic [SLOT_AW-1:0]       cr_idx_d;
	status_t                  cr_status_d;

	// Modify stage
	slot_entry_t              ne;
	logic [SLOT_AW-1:0]       hnd_idx;
	logic                     found;
	status_t                  lk;
	logic                     rep_ok;
	status_t                  sts;
	logic                     recv_hit;
	logic                     rep_pa_ini;
	logic                     me_live;
	logic                     peer_live;
	logic [POS_W-1:0]         snd_hd, rcv_hd;
	logic [LEN_W-1:0]         snd_ln, rcv_ln;
	logic [LEN_W:0]           tail_sum, tail, head_inc, head_nx;

	sct_meta_store u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (meta_req),
		.rd_data (meta_rd)
	);

	sct_word_store u_words (
		.clk     (clk),
		.req     (word_req),
		.rd_data (word_rd)
	);

	assign out_free   = !rsp_valid || !rsp_stall;
	assign req_stall  = !((state_q == FSM_IDLE) || ((state_q == FSM_FIN) && out_free));
	assign accept     = req_valid && !req_stall;
	assign is_rst_req = (req_type == REQ_RESET_ALL);

	// First reusable slot among those in use; otherwise append.
	always_comb begin
		pick_found = 1'b0;
		pick_idx   = '0;
		for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
			if (closed_q[i] && (i < int'(in_use_q))) begin
				pick_found = 1'b1;
				pick_idx   = SLOT_AW'(i);
			end
		end
	end

	assign cap_ok     = (capacity != 8'd0) && (int'(capacity) <= QUEUE_DEPTH);
	assign table_full = int'(in_use_q) >= SESSION_SLOTS;
	assign cr_idx_d   = pick_found ? pick_idx : SLOT_AW'(in_use_q);

	always_comb begin
		if (!cap_ok) begin
			cr_status_d = STS_INVALID_ARG;
		end else if (!pick_found && table_full) begin
			cr_status_d = STS_EXHAUSTED;
		end else begin
			cr_status_d = STS_OK;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) state_d = is_rst_req ? FSM_SWEEP : FSM_META;
			end
			FSM_META: begin
				state_d = FSM_FIN;
			end
			FSM_SWEEP: begin
				if (sweep_q == SWEEP_LAST) state_d = FSM_FIN;
			end
			FSM_FIN: begin
				if (out_free) begin
					if (accept) state_d = is_rst_req ? FSM_SWEEP : FSM_META;
					else state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Handle checks and queue arithmetic on the entry just read
	always_comb begin
		hnd_idx    = SLOT_AW'(slot_q);
		found      = int'(slot_q) < int'(in_use_q);
		if (!found) begin
			lk = STS_NOT_FOUND;
		end else if (meta_rd.gen != gen_q) begin
			lk = STS_STALE;
		end else begin
			lk = STS_OK;
		end
		me_live    = ini_q ? meta_rd.ini_live : meta_rd.rsp_live;
		peer_live  = ini_q ? meta_rd.rsp_live : meta_rd.ini_live;
		snd_hd     = ini_q ? meta_rd.fwd_head : meta_rd.bwd_head;
		snd_ln     = ini_q ? meta_rd.fwd_len  : meta_rd.bwd_len;
		rcv_hd     = ini_q ? meta_rd.bwd_head : meta_rd.fwd_head;
		rcv_ln     = ini_q ? meta_rd.bwd_len  : meta_rd.fwd_len;
		// head and length are both below the capacity, so one subtract wraps
		tail_sum   = (LEN_W + 1)'(snd_hd) + (LEN_W + 1)'(snd_ln);
		tail       = (tail_sum >= (LEN_W + 1)'(meta_rd.cap)) ?
			tail_sum - (LEN_W + 1)'(meta_rd.cap) : tail_sum;
		head_inc   = (LEN_W + 1)'(rcv_hd) + (LEN_W + 1)'(1);
		head_nx    = (head_inc == (LEN_W + 1)'(meta_rd.cap)) ? '0 : head_inc;
	end

	// Memory commands, write-back entry and staged response
	always_comb begin
		meta_req     = '0;
		word_req     = '0;
		in_use_d     = in_use_q;
		closed_d     = closed_q;
		sweep_d      = sweep_q;
		res_status_d = res_status_q;
		res_recv_d   = res_recv_q;
		res_slot_d   = res_slot_q;
		res_gen_d    = res_gen_q;
		res_state_d  = res_state_q;
		res_ob_d     = res_ob_q;
		res_pa_d     = res_pa_q;
		ne           = meta_rd;
		rep_ok       = (lk == STS_OK);
		sts          = lk;
		recv_hit     = 1'b0;
		rep_pa_ini   = ini_q;

		// Read the entry the new item works on.
		if (accept) begin
			meta_req.rd_en = 1'b1;
			if (is_rst_req) begin
				meta_req.rd_addr = '0;
			end else if (req_type == REQ_CREATE) begin
				meta_req.rd_addr = cr_idx_d;
			end else begin
				meta_req.rd_addr = SLOT_AW'(slot);
			end
			sweep_d = '0;
		end

		case (state_q)
			FSM_META: begin
				unique case (req_kind_t'(kind_q))
					REQ_CREATE: begin
						sts         = cr_status_q;
						rep_ok      = (cr_status_q == STS_OK);
						rep_pa_ini  = 1'b1;
						ne.gen      = gen_advance(meta_rd.gen);
						ne.state    = SS_OPEN;
						ne.ini_live = 1'b1;
						ne.rsp_live = 1'b1;
						ne.oblig    = '0;
						ne.cap      = LEN_W'(cap_q);
						ne.fwd_head = '0;
						ne.fwd_len  = '0;
						ne.bwd_head = '0;
						ne.bwd_len  = '0;
						if (rep_ok) begin
							meta_req.wr_en     = 1'b1;
							closed_d[cr_idx_q] = 1'b0;
							if (cr_append_q) in_use_d = in_use_q + USE_W'(1);
						end
					end
					REQ_DROP: begin
						if (rep_ok) begin
							if (ini_q) ne.ini_live = 1'b0;
							else ne.rsp_live = 1'b0;
							if (!ne.ini_live && !ne.rsp_live) begin
								ne.state          = SS_CLOSED;
								closed_d[hnd_idx] = 1'b1;
							end else if (meta_rd.state == SS_OPEN) begin
								ne.state = SS_HALF;
							end
							meta_req.wr_en = 1'b1;
						end
					end
					REQ_SEND: begin
						if (rep_ok) begin
							if (!me_live) begin
								sts = STS_INVALID_STATE;
							end else if (!peer_live) begin
								sts = STS_DISCONNECTED;
							end else if (snd_ln >= meta_rd.cap) begin
								sts = STS_FULL;
							end else begin
								word_req.wr_en   = 1'b1;
								word_req.wr_addr = {!ini_q, hnd_idx, POS_W'(tail)};
								word_req.wr_data = value_q;
								if (ini_q) begin
									ne.fwd_len = meta_rd.fwd_len + LEN_W'(1);
									ne.oblig   = meta_rd.oblig + OB_W'(1);
								end else begin
									ne.bwd_len = meta_rd.bwd_len + LEN_W'(1);
								end
								meta_req.wr_en = 1'b1;
							end
						end
					end
					REQ_RECV: begin
						if (rep_ok) begin
							if (rcv_ln != '0) begin
								word_req.rd_en   = 1'b1;
								word_req.rd_addr = {ini_q, hnd_idx, rcv_hd};
								if (ini_q) begin
									ne.bwd_head = POS_W'(head_nx);
									ne.bwd_len  = meta_rd.bwd_len - LEN_W'(1);
								end else begin
									ne.fwd_head = POS_W'(head_nx);
									ne.fwd_len  = meta_rd.fwd_len - LEN_W'(1);
									if (meta_rd.oblig != '0) ne.oblig = meta_rd.oblig - OB_W'(1);
								end
								meta_req.wr_en = 1'b1;
								recv_hit       = 1'b1;
							end else if (!peer_live) begin
								sts = STS_DISCONNECTED;
							end else begin
								sts = STS_WOULD_BLOCK;
							end
						end
					end
					REQ_QUERY: begin
					end
					default: begin
						// undefined kinds report the handle like a query
						sts = STS_INVALID_ARG;
					end
				endcase

				meta_req.wr_addr = (kind_q == REQ_CREATE) ? cr_idx_q : hnd_idx;
				meta_req.wr_data = ne;

				res_status_d = sts;
				res_recv_d   = recv_hit;
				res_slot_d   = ((kind_q == REQ_CREATE) && rep_ok) ? 4'(cr_idx_q) : 4'd0;
				res_gen_d    = ((kind_q == REQ_CREATE) && rep_ok) ? ne.gen : 16'd0;
				res_state_d  = rep_ok ? ne.state : SS_CLOSED;
				res_ob_d     = !rep_ok ? 5'd0 :
					(ne.oblig > OB_W'(31)) ? 5'd31 : ne.oblig[4:0];
				res_pa_d     = rep_ok && (rep_pa_ini ? ne.rsp_live : ne.ini_live);
			end
			FSM_SWEEP: begin
				// Advance every generation and close every slot; queues stay.
				ne.gen           = gen_advance(meta_rd.gen);
				ne.state         = SS_CLOSED;
				ne.ini_live      = 1'b0;
				ne.rsp_live      = 1'b0;
				ne.oblig         = '0;
				meta_req.wr_en   = 1'b1;
				meta_req.wr_addr = sweep_q;
				meta_req.wr_data = ne;
				if (sweep_q != SWEEP_LAST) begin
					meta_req.rd_en   = 1'b1;
					meta_req.rd_addr = sweep_q + SLOT_AW'(1);
					sweep_d          = sweep_q + SLOT_AW'(1);
				end else begin
					in_use_d = '0;
					closed_d = '1;
				end
				res_status_d = STS_OK;
				res_recv_d   = 1'b0;
				res_slot_d   = 4'd0;
				res_gen_d    = 16'd0;
				res_state_d  = SS_CLOSED;
				res_ob_d     = 5'd0;
				res_pa_d     = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			in_use_q  <= '0;
			closed_q  <= '1;
			sweep_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			in_use_q <= in_use_d;
			closed_q <= closed_d;
			sweep_q  <= sweep_d;
			if ((state_q == FSM_FIN) && out_free) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Request hold, staged response and response register
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= req_type;
			slot_q      <= slot;
			gen_q       <= generation;
			ini_q       <= from_initiator;
			value_q     <= value;
			cap_q       <= capacity;
			cr_idx_q    <= cr_idx_d;
			cr_append_q <= !pick_found;
			cr_status_q <= cr_status_d;
		end
		res_status_q <= res_status_d;
		res_recv_q   <= res_recv_d;
		res_slot_q   <= res_slot_d;
		res_gen_q    <= res_gen_d;
		res_state_q  <= res_state_d;
		res_ob_q     <= res_ob_d;
		res_pa_q     <= res_pa_d;
		if ((state_q == FSM_FIN) && out_free) begin
			status         <= res_status_q;
			recv_word      <= res_recv_q ? word_rd : 64'd0;
			out_slot       <= res_slot_q;
			out_generation <= res_gen_q;
			session_state  <= res_state_q;
			obligations    <= res_ob_q;
			partner_live   <= res_pa_q;
		end
	end

endmodule

`default_nettype wire

### rtl/sct_checker.sv
// Port-level checks of the session channel table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "session_channel_table_unit_macros.svh"

module sct_checker import sct_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_stall,
	input wire logic        rsp_valid,
	input wire logic        rsp_stall,
	input wire logic [3:0]  status,
	input wire logic [63:0] recv_word,
	input wire logic [15:0] out_generation,
	input wire logic [1:0]  session_state,
	input wire logic        partner_live
);

	// hold a stalled response
	`SCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(recv_word) && $stable(status), "stalled response changed")

	// one item in flight: the cycle after a take the request side is stalled
	`SCT_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "item taken while busy")

	// a failed request carries no word and no tag
	`SCT_ASSERT(a_fail_clean, rsp_valid && (status != STS_OK), (recv_word == 64'd0) && (out_generation == 16'd0), "failed response carries data")

	// a closed session has no live peer
	`SCT_ASSERT(a_closed_peer, rsp_valid && (session_state == SS_CLOSED), !partner_live, "closed session reports live peer")

endmodule

bind session_channel_table_unit sct_checker u_sct_checker (.*);

`default_nettype wire

### bench/session_channel_table_unit_tb.sv
// Testbench for the session channel table: directed table, random traffic, predicted results.
`timescale 1ns / 1ps
`default_nettype none

module session_channel_table_unit_tb;
	import sct_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 900;

	// request kinds with no defined meaning
	localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
	localparam logic [2:0] REQ_UNDEF_HI = 3'd7;

	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  sl;
		logic [15:0] gen;
		logic        ini;
		logic [63:0] val;
		logic [7:0]  cap;
	} request_t;

	typedef struct {
		status_t     sts;
		logic [63:0] val;
		logic [3:0]  sl;
		logic [15:0] gen;
		logic [1:0]  state;
		logic [4:0]  ob;
		logic        pa;
	} reply_t;

	typedef struct {
		request_t req;
		logic     typed;
		reply_t   want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  req_type = '0;
	logic [3:0]  slot = '0;
	logic [15:0] generation = '0;
	logic        from_initiator = 1'b0;
	logic [63:0] value = '0;
	logic [7:0]  capacity = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [3:0]  status;
	logic [63:0] recv_word;
	logic [3:0]  out_slot;
	logic [15:0] out_generation;
	logic [1:0]  session_state;
	logic [4:0]  obligations;
	logic        partner_live;

	session_channel_table_unit uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the slot table
	logic [15:0] tbl_gen [SESSION_SLOTS];
	sess_state_t tbl_state [SESSION_SLOTS];
	logic        tbl_ini [SESSION_SLOTS];
	logic        tbl_rsp [SESSION_SLOTS];
	int          tbl_ob [SESSION_SLOTS];
	int          tbl_cap [SESSION_SLOTS];
	int          fwd_head [SESSION_SLOTS];
	int          fwd_len [SESSION_SLOTS];
	int          bwd_head [SESSION_SLOTS];
	int          bwd_len [SESSION_SLOTS];
	logic [63:0] fwd_word [SESSION_SLOTS * QUEUE_DEPTH];
	logic [63:0] bwd_word [SESSION_SLOTS * QUEUE_DEPTH];
	int          slots_used;

	reply_t    pending_replies [$];
	stim_row_t stim_table [$];
	int        row_idx = 0;
	int        mismatches;
	int        cycles;

	function automatic logic [15:0] next_tag(input logic [15:0] g);
		return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
	endfunction

	function automatic status_t find_handle(input int s, input logic [15:0] g);
		if (s >= slots_used) return STS_NOT_FOUND;
		if (tbl_gen[s] != g) return STS_STALE;
		return STS_OK;
	endfunction

	function automatic int depth_of(input int s);
		if (tbl_cap[s] == 0) return 1;
		if (tbl_cap[s] > QUEUE_DEPTH) return QUEUE_DEPTH;
		return tbl_cap[s];
	endfunction

	// Apply one request to the shadow table and return the reply it should give.
	function automatic reply_t apply_request(input request_t r);
		reply_t      rep;
		int          s, c, idx, tail;
		logic        rini, me, peer, ok;
		s = r.sl;
		rep = '{STS_OK, '0, '0, '0, '0, '0, 1'b0};
		case (r.kind)
			REQ_RESET_ALL: begin
				for (int i = 0; i < SESSION_SLOTS; i++) begin
					tbl_gen[i] = next_tag(tbl_gen[i]);
					tbl_state[i] = SS_CLOSED;
					tbl_ini[i] = 1'b0;
					tbl_rsp[i] = 1'b0;
					tbl_ob[i] = 0;
				end
				slots_used = 0;
			end
			REQ_CREATE: begin
				if (r.cap == 0 || r.cap > QUEUE_DEPTH) begin
					rep.sts = STS_INVALID_ARG;
				end else begin
					idx = -1;
					for (int i = 0; i < slots_used; i++)
						if (idx < 0 && tbl_state[i] == SS_CLOSED && !tbl_ini[i] && !tbl_rsp[i])
							idx = i;
					if (idx < 0) begin
						if (slots_used >= SESSION_SLOTS) rep.sts = STS_EXHAUSTED;
						else begin
							idx = slots_used;
							slots_used++;
						end
					end
					if (rep.sts == STS_OK) begin
						tbl_gen[idx] = next_tag(tbl_gen[idx]);
						tbl_state[idx] = SS_OPEN;
						tbl_ini[idx] = 1'b1;
						tbl_rsp[idx] = 1'b1;
						tbl_ob[idx] = 0;
						tbl_cap[idx] = r.cap;
						fwd_head[idx] = 0;
						fwd_len[idx] = 0;
						bwd_head[idx] = 0;
						bwd_len[idx] = 0;
						rep.sl = idx[3:0];
						rep.gen = tbl_gen[idx];
					end
				end
			end
			REQ_DROP, REQ_QUERY: begin
				rep.sts = find_handle(s, r.gen);
				if (rep.sts == STS_OK && r.kind == REQ_DROP) begin
					if (r.ini) tbl_ini[s] = 1'b0;
					else tbl_rsp[s] = 1'b0;
					if (!tbl_ini[s] && !tbl_rsp[s]) tbl_state[s] = SS_CLOSED;
					else if (tbl_state[s] == SS_OPEN) tbl_state[s] = SS_HALF;
				end
			end
			REQ_SEND: begin
				rep.sts = find_handle(s, r.gen);
				if (rep.sts == STS_OK) begin
					me = r.ini ? tbl_ini[s] : tbl_rsp[s];
					peer = r.ini ? tbl_rsp[s] : tbl_ini[s];
					c = depth_of(s);
					if (!me) rep.sts = STS_INVALID_STATE;
					else if (!peer) rep.sts = STS_DISCONNECTED;
					else if (r.ini) begin
						if (fwd_len[s] >= c) rep.sts = STS_FULL;
						else begin
							tail = (fwd_head[s] % c + fwd_len[s]) % c;
							fwd_word[s * QUEUE_DEPTH + tail] = r.val;
							fwd_len[s]++;
							tbl_ob[s]++;
						end
					end else begin
						if (bwd_len[s] >= c) rep.sts = STS_FULL;
						else begin
							tail = (bwd_head[s] % c + bwd_len[s]) % c;
							bwd_word[s * QUEUE_DEPTH + tail] = r.val;
							bwd_len[s]++;
						end
					end
				end
			end
			REQ_RECV: begin
				rep.sts = find_handle(s, r.gen);
				if (rep.sts == STS_OK) begin
					peer = r.ini ? tbl_rsp[s] : tbl_ini[s];
					c = depth_of(s);
					if (r.ini && bwd_len[s] != 0) begin
						rep.val = bwd_word[s * QUEUE_DEPTH + bwd_head[s] % c];
						bwd_head[s] = (bwd_head[s] % c + 1) % c;
						bwd_len[s]--;
					end else if (!r.ini && fwd_len[s] != 0) begin
						rep.val = fwd_word[s * QUEUE_DEPTH + fwd_head[s] % c];
						fwd_head[s] = (fwd_head[s] % c + 1) % c;
						fwd_len[s]--;
						if (tbl_ob[s] > 0) tbl_ob[s]--;
					end else if (!peer) rep.sts = STS_DISCONNECTED;
					else rep.sts = STS_WOULD_BLOCK;
				end
			end
			default: rep.sts = STS_INVALID_ARG;
		endcase
		// Report on the handle, or on the new slot for a create
		if (r.kind == REQ_CREATE) begin
			s = rep.sl;
			rini = 1'b1;
			ok = (rep.sts == STS_OK);
		end else begin
			rini = r.ini;
			ok = (find_handle(s, r.gen) == STS_OK);
		end
		if (ok) begin
			rep.state = tbl_state[s];
			rep.ob = (tbl_ob[s] > 31) ? 5'd31 : tbl_ob[s][4:0];
			rep.pa = rini ? tbl_rsp[s] : tbl_ini[s];
		end
		return rep;
	endfunction

	// Take the request on acceptance; check the response against the oldest expectation.
	always @(posedge clk) begin
		request_t  r;
		reply_t    p, w, got;
		stim_row_t cur_row;
		if (arst_n && req_valid && !req_stall) begin
			r = '{req_type, slot, generation, from_initiator, value, capacity};
			p = apply_request(r);
			if (row_idx < stim_table.size() && stim_table[row_idx].typed)
				pending_replies.push_back(stim_table[row_idx].want);
			else
				pending_replies.push_back(p);
			row_idx++;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = '{status_t'(status), recv_word, out_slot, out_generation,
				session_state, obligations, partner_live};
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status %0d", status);
			end else begin
				w = pending_replies.pop_front();
				if (got.sts != w.sts || got.val != w.val || got.sl != w.sl ||
						got.gen != w.gen || got.state != w.state || got.ob != w.ob ||
						got.pa != w.pa) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: want sts %0d val %h slot %0d gen %h st %0d ob %0d pa %0d",
							w.sts, w.val, w.sl, w.gen, w.state, w.ob, w.pa);
						$display("          got  sts %0d val %h slot %0d gen %h st %0d ob %0d pa %0d",
							got.sts, got.val, got.sl, got.gen, got.state, got.ob, got.pa);
					end
				end
			end
		end
	end

	// Receiver back-pressure: switch between calm, choppy and long stalls
	always @(posedge clk) begin
		int mode, left;
		if (left == 0) begin
			mode = $urandom_range(0, 2);
			left = $urandom_range(10, 80);
		end
		left--;
		case (mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 99) < 35);
			default: rsp_stall <= ($urandom_range(0, 99) < 85);
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it.
	task automatic offer(input request_t r, input int gap);
		logic held;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= r.kind;
		slot <= r.sl;
		generation <= r.gen;
		from_initiator <= r.ini;
		value <= r.val;
		capacity <= r.cap;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			held = req_stall;
			@(posedge clk);
		end while (held);
	endtask

	function automatic stim_row_t row(input logic [2:0] k, input int s, input logic [15:0] g,
			input logic i, input logic [63:0] v, input logic [7:0] c);
		stim_row_t t;
		t.req = '{k, s[3:0], g, i, v, c};
		t.typed = 1'b0;
		t.want = '{STS_OK, '0, '0, '0, '0, '0, 1'b0};
		return t;
	endfunction

	function automatic stim_row_t typed_row(input stim_row_t t, input status_t st,
			input int sl, input logic [15:0] g, input sess_state_t ss, input logic pa);
		t.typed = 1'b1;
		t.want = '{st, '0, sl[3:0], g, ss, '0, pa};
		return t;
	endfunction

	// Random item: mostly live handles, some noise
	function automatic request_t random_request(input int create_weight);
		request_t r;
		int       pick, s;
		pick = $urandom_range(0, 99);
		r.val = {$urandom, $urandom};
		r.ini = 1'($urandom_range(0, 1));
		r.cap = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, QUEUE_DEPTH));
		if (pick < create_weight) r.kind = REQ_CREATE;
		else if (pick < create_weight + 8) r.kind = REQ_DROP;
		else if (pick < create_weight + 40) r.kind = REQ_SEND;
		else if (pick < create_weight + 75) r.kind = REQ_RECV;
		else if (pick < 97) r.kind = REQ_QUERY;
		else if (pick < 98) r.kind = REQ_RESET_ALL;
		else r.kind = ($urandom_range(0, 1) == 0) ? REQ_UNDEF_LO : REQ_UNDEF_HI;
		if (slots_used > 0 && $urandom_range(0, 99) < 85) begin
			s = $urandom_range(0, slots_used - 1);
			r.sl = s[3:0];
			r.gen = tbl_gen[s];
		end else begin
			r.sl = 4'($urandom);
			r.gen = ($urandom_range(0, 1) == 0) ? 16'($urandom) : tbl_gen[r.sl];
		end
		return r;
	endfunction

	initial begin
		request_t  r;
		int        gap, burst, weight;
		logic [63:0] ones;
		ones = '1;
		for (int i = 0; i < SESSION_SLOTS; i++) begin
			tbl_gen[i] = '0;
			tbl_state[i] = SS_CLOSED;
			tbl_ini[i] = 1'b0;
			tbl_rsp[i] = 1'b0;
			tbl_ob[i] = 0;
			tbl_cap[i] = 0;
			fwd_head[i] = 0;
			fwd_len[i] = 0;
			bwd_head[i] = 0;
			bwd_len[i] = 0;
		end
		slots_used = 0;
		mismatches = 0;
		cycles = 0;

		// Directed table: empty table, bad arguments, queue corner cases, reuse, reset all
		stim_table.push_back(typed_row(row(REQ_QUERY, 0, 0, 0, 0, 0),
			STS_NOT_FOUND, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_UNDEF_LO, 15, 16'hFFFF, 1, ones, 8'hFF),
			STS_INVALID_ARG, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_UNDEF_HI, 0, 0, 0, 0, 0),
			STS_INVALID_ARG, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_CREATE, 0, 0, 0, 0, 0),
			STS_INVALID_ARG, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_CREATE, 0, 0, 0, 0, 17),
			STS_INVALID_ARG, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_CREATE, 0, 0, 0, 0, 8'hFF),
			STS_INVALID_ARG, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_CREATE, 0, 0, 0, 0, 16),
			STS_OK, 0, 1, SS_OPEN, 1));
		stim_table.push_back(typed_row(row(REQ_CREATE, 0, 0, 0, 0, 1),
			STS_OK, 1, 1, SS_OPEN, 1));
		stim_table.push_back(row(REQ_SEND, 0, 1, 1, ones, 0));
		stim_table.push_back(row(REQ_SEND, 0, 1, 0, 0, 0));
		stim_table.push_back(row(REQ_RECV, 0, 1, 0, 0, 0));
		stim_table.push_back(row(REQ_RECV, 0, 1, 0, 0, 0));
		stim_table.push_back(row(REQ_RECV, 0, 1, 1, 0, 0));
		stim_table.push_back(row(REQ_SEND, 1, 1, 1, 64'hA5A5_5A5A_0F0F_F0F0, 0));
		stim_table.push_back(row(REQ_SEND, 1, 1, 1, 64'h1, 0));
		stim_table.push_back(typed_row(row(REQ_QUERY, 0, 2, 0, 0, 0),
			STS_STALE, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_QUERY, 5, 1, 0, 0, 0),
			STS_NOT_FOUND, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(row(REQ_DROP, 1, 1, 0, 0, 0));
		stim_table.push_back(row(REQ_SEND, 1, 1, 1, 0, 0));
		stim_table.push_back(row(REQ_SEND, 1, 1, 0, 0, 0));
		stim_table.push_back(row(REQ_RECV, 1, 1, 0, 0, 0));
		stim_table.push_back(row(REQ_RECV, 1, 1, 1, 0, 0));
		stim_table.push_back(row(REQ_DROP, 1, 1, 1, 0, 0));
		stim_table.push_back(row(REQ_CREATE, 0, 0, 0, 0, 8));
		stim_table.push_back(typed_row(row(REQ_RESET_ALL, 0, 1, 1, 0, 0),
			STS_OK, 0, 0, SS_CLOSED, 0));
		stim_table.push_back(typed_row(row(REQ_QUERY, 0, 2, 0, 0, 0),
			STS_NOT_FOUND, 0, 0, SS_CLOSED, 0));

		// Hold reset, then release it on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; the acceptance block looks each row up as it is taken
		for (int i = 0; i < stim_table.size(); i++) begin
			r = stim_table[i].req;
			offer(r, $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
		end

		// Random traffic in bursts; the create weight drifts so the table fills and drains
		burst = 0;
		weight = 10;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) weight = $urandom_range(2, 20);
			// Drain everything once mid-run before carrying on
			if (n == RANDOM_ITEMS / 2) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_replies.size() != 0) @(posedge clk);
			end
			gap = 0;
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			burst--;
			offer(random_request(weight), gap);
		end
		req_valid <= 1'b0;

		// Let the last responses arrive, then a short settle
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
